[src/gcc_pkg.sv]
// Shared types and codes for the greedy coin change block.
`default_nettype none

package gcc_pkg;

  localparam int OP_BITS = 2;

  localparam logic [OP_BITS-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_BITS-1:0] OP_CHANGE = 2'd1;
  localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd2;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_INS_RD   = 7'b0000010,
    ST_INS_CMP  = 7'b0000100,
    ST_INS_PUT  = 7'b0001000,
    ST_CHG_RD   = 7'b0010000,
    ST_CHG_LOAD = 7'b0100000,
    ST_CHG_DIV  = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

[src/gcc_divider.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none

module gcc_divider #(
  parameter int VALUE_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [VALUE_BITS-1:0] dividend,
  input  wire logic [VALUE_BITS-1:0] divisor,
  output logic                       done,
  output logic [VALUE_BITS-1:0]      quotient,
  output logic [VALUE_BITS-1:0]      remainder
);

  localparam int STEP_BITS = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] acc;
  logic [VALUE_BITS-1:0] quo;
  logic [VALUE_BITS-1:0] dsr;
  logic [STEP_BITS-1:0]  steps;
  logic                  active;
  logic [VALUE_BITS:0]   trial;
  logic [VALUE_BITS:0]   diff;
  logic                  fits;

  assign trial = {acc, quo[VALUE_BITS-1]};
  assign diff  = trial - {1'b0, dsr};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      steps  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        steps  <= STEP_BITS'(VALUE_BITS);
        acc    <= '0;
        quo    <= dividend;
        dsr    <= divisor;
      end else if (active) begin
        acc   <= fits ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
        quo   <= {quo[VALUE_BITS-2:0], fits};
        steps <= steps - 1'b1;
        if (steps == STEP_BITS'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = acc;

endmodule

`default_nettype wire

[src/greedy_coin_change.sv]
// Top level of the greedy coin change block: sorted table and change walk.
//
// Command channel: a beat (op, denomination, amount) is taken at a clock edge
// with start high and busy low. Add keeps the table in ascending order by
// moving larger entries up one place, each through a read state and a
// compare state; the compare state, or the put state at the bottom of the
// table, writes the new value. An add of a zero denomination or to a full
// table is dropped. Clear empties the table; an unused op code is taken
// and dropped. Change walks the table from the largest entry down. Each
// entry passes through a read, a load and a divide state, the last waiting
// for the bit-serial divider to finish. Each entry yields one result
// beat on coin_value, coin_count, remaining and last, marked by strobe for
// one cycle; last is high on the final beat. An empty table yields one beat
// with coin_value 0 and coin_count 0 the cycle after the command.
// Results cannot be held off; the receiver takes every strobe beat.
// Reset empties the table and returns the block to idle.
`default_nettype none

module greedy_coin_change #(
  parameter int TABLE_DEPTH = 16,
  parameter int VALUE_BITS  = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [gcc_pkg::OP_BITS-1:0] op,
  input  wire logic [VALUE_BITS-1:0]       denomination,
  input  wire logic [VALUE_BITS-1:0]       amount,
  output logic                             strobe,
  output logic [VALUE_BITS-1:0]            coin_value,
  output logic [VALUE_BITS-1:0]            coin_count,
  output logic [VALUE_BITS-1:0]            remaining,
  output logic                             last
);

  localparam int ADDR_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_BITS  = $clog2(TABLE_DEPTH + 1);

  gcc_pkg::state_t state;

  logic [VALUE_BITS-1:0] mem [TABLE_DEPTH];
  logic [VALUE_BITS-1:0] rd_data;
  logic                  mem_we;
  logic                  mem_re;
  logic [ADDR_BITS-1:0]  mem_waddr;
  logic [ADDR_BITS-1:0]  mem_raddr;
  logic [VALUE_BITS-1:0] mem_wdata;

  logic [CNT_BITS-1:0]   entry_count;
  logic [CNT_BITS-1:0]   pos;
  logic [CNT_BITS-1:0]   pos_dec;
  logic [VALUE_BITS-1:0] ins_val;
  logic [ADDR_BITS-1:0]  idx;
  logic [VALUE_BITS-1:0] left;
  logic [VALUE_BITS-1:0] coin;

  logic                  div_start;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quo;
  logic [VALUE_BITS-1:0] div_rem;

  function automatic logic [ADDR_BITS-1:0] pos_from_count(input logic [CNT_BITS-1:0] cnt);
    logic [CNT_BITS-1:0] top;
    top = cnt - 1'b1;
    return top[ADDR_BITS-1:0];
  endfunction

  assign busy    = (state != gcc_pkg::ST_IDLE);
  assign pos_dec = pos - 1'b1;

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = pos[ADDR_BITS-1:0];
    mem_wdata = ins_val;
    mem_raddr = pos_dec[ADDR_BITS-1:0];
    div_start = 1'b0;
    unique case (state)
      gcc_pkg::ST_INS_RD: begin
        mem_re = 1'b1;
      end
      gcc_pkg::ST_INS_CMP: begin
        mem_we = 1'b1;
        if (rd_data > ins_val) begin
          mem_wdata = rd_data;
        end
      end
      gcc_pkg::ST_INS_PUT: begin
        mem_we = 1'b1;
      end
      gcc_pkg::ST_CHG_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx;
      end
      gcc_pkg::ST_CHG_LOAD: begin
        div_start = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  gcc_divider #(
    .VALUE_BITS(VALUE_BITS)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (left),
    .divisor  (rd_data),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= gcc_pkg::ST_IDLE;
      entry_count <= '0;
      strobe      <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        gcc_pkg::ST_IDLE: begin
          if (start) begin
            unique case (op)
              gcc_pkg::OP_ADD: begin
                if (denomination != '0 && entry_count < CNT_BITS'(TABLE_DEPTH)) begin
                  ins_val <= denomination;
                  pos     <= entry_count;
                  state   <= (entry_count == '0) ? gcc_pkg::ST_INS_PUT
                                                 : gcc_pkg::ST_INS_RD;
                end
              end
              gcc_pkg::OP_CHANGE: begin
                left <= amount;
                if (entry_count == '0) begin
                  strobe     <= 1'b1;
                  coin_value <= '0;
                  coin_count <= '0;
                  remaining  <= amount;
                  last       <= 1'b1;
                end else begin
                  idx   <= pos_from_count(entry_count);
                  state <= gcc_pkg::ST_CHG_RD;
                end
              end
              gcc_pkg::OP_CLEAR: begin
                entry_count <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        gcc_pkg::ST_INS_RD: begin
          state <= gcc_pkg::ST_INS_CMP;
        end
        gcc_pkg::ST_INS_CMP: begin
          if (rd_data > ins_val) begin
            pos   <= pos_dec;
            state <= (pos == CNT_BITS'(1)) ? gcc_pkg::ST_INS_PUT : gcc_pkg::ST_INS_RD;
          end else begin
            entry_count <= entry_count + 1'b1;
            state       <= gcc_pkg::ST_IDLE;
          end
        end
        gcc_pkg::ST_INS_PUT: begin
          entry_count <= entry_count + 1'b1;
          state       <= gcc_pkg::ST_IDLE;
        end
        gcc_pkg::ST_CHG_RD: begin
          state <= gcc_pkg::ST_CHG_LOAD;
        end
        gcc_pkg::ST_CHG_LOAD: begin
          coin  <= rd_data;
          state <= gcc_pkg::ST_CHG_DIV;
        end
        gcc_pkg::ST_CHG_DIV: begin
          if (div_done) begin
            strobe     <= 1'b1;
            coin_value <= coin;
            coin_count <= div_quo;
            remaining  <= div_rem;
            last       <= (idx == '0);
            left       <= div_rem;
            if (idx == '0) begin
              state <= gcc_pkg::ST_IDLE;
            end else begin
              idx   <= idx - 1'b1;
              state <= gcc_pkg::ST_CHG_RD;
            end
          end
        end
        default: begin
          state <= gcc_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[verif/gcc_checker.sv]
// Checker for the greedy coin change block: predicts result beats and compares them.
module gcc_checker #(
  parameter int DEPTH = 16,
  parameter int VB    = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [gcc_pkg::OP_BITS-1:0] op,
  input  logic [VB-1:0]               denomination,
  input  logic [VB-1:0]               amount,
  input  logic                        strobe,
  input  logic [VB-1:0]               coin_value,
  input  logic [VB-1:0]               coin_count,
  input  logic [VB-1:0]               remaining,
  input  logic                        last,
  output int                          fail_count,
  output int                          pending,
  output int                          beats_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [VB-1:0] value;
    logic [VB-1:0] count;
    logic [VB-1:0] rest;
    logic          fin;
  } coin_beat_t;

  coin_beat_t    due_beats[$];
  logic [VB-1:0] denoms[DEPTH];
  int            n_denoms = 0;
  int            errs = 0;
  int            checked = 0;

  function automatic void insert_denom(logic [VB-1:0] v);
    int pos;
    if (v == '0 || n_denoms >= DEPTH) return;
    pos = n_denoms;
    while (pos > 0 && denoms[pos-1] > v) begin
      denoms[pos] = denoms[pos-1];
      pos--;
    end
    denoms[pos] = v;
    n_denoms++;
  endfunction

  function automatic void predict_change(logic [VB-1:0] amt);
    logic [VB-1:0] left;
    logic [VB-1:0] coin;
    logic [VB-1:0] cnt;
    coin_beat_t    b;
    left = amt;
    if (n_denoms == 0) begin
      b = '{value: '0, count: '0, rest: left, fin: 1'b1};
      due_beats = {due_beats, b};
      return;
    end
    for (int k = 0; k < n_denoms; k++) begin
      coin = denoms[n_denoms-1-k];
      cnt = '0;
      if (coin != '0) begin
        cnt = left / coin;
        left = left - cnt * coin;
      end
      b = '{value: coin, count: cnt, rest: left, fin: (k + 1 == n_denoms)};
      due_beats = {due_beats, b};
    end
  endfunction

  always @(posedge clk) begin
    coin_beat_t exp_beat;
    if (rst) begin
      n_denoms = 0;
      due_beats.delete();
    end else begin
      if (strobe) begin
        if (due_beats.size() == 0) begin
          $display("%0t: result beat with none due: value=%0d count=%0d rest=%0d last=%0b",
                   $time, coin_value, coin_count, remaining, last);
          errs++;
        end else begin
          exp_beat = due_beats.pop_front();
          checked++;
          if (coin_value !== exp_beat.value) begin
            $display("%0t: coin_value expected %0d actual %0d", $time, exp_beat.value,
                     coin_value);
            errs++;
          end
          if (coin_count !== exp_beat.count) begin
            $display("%0t: coin_count expected %0d actual %0d", $time, exp_beat.count,
                     coin_count);
            errs++;
          end
          if (remaining !== exp_beat.rest) begin
            $display("%0t: remaining expected %0d actual %0d", $time, exp_beat.rest,
                     remaining);
            errs++;
          end
          if (last !== exp_beat.fin) begin
            $display("%0t: last expected %0b actual %0b", $time, exp_beat.fin, last);
            errs++;
          end
        end
      end
      if (start && !busy) begin
        case (op)
          gcc_pkg::OP_ADD:    insert_denom(denomination);
          gcc_pkg::OP_CHANGE: predict_change(amount);
          gcc_pkg::OP_CLEAR:  n_denoms = 0;
          default:            ;
        endcase
      end
    end
    fail_count    <= errs;
    pending       <= due_beats.size();
    beats_checked <= checked;
  end
endmodule

[verif/tb_greedy_coin_change.sv]
// Testbench top for the greedy coin change block: stimulus, watchdog and verdict.
module tb_greedy_coin_change;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VB          = 16;
  localparam int DEPTH       = 16;
  localparam int ITEMS       = 370;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN       = 400;

  localparam logic [gcc_pkg::OP_BITS-1:0] OP_SPARE = 2'd3;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic [gcc_pkg::OP_BITS-1:0] op = '0;
  logic [VB-1:0]               denomination = '0;
  logic [VB-1:0]               amount = '0;
  logic                        busy;
  logic                        strobe;
  logic [VB-1:0]               coin_value;
  logic [VB-1:0]               coin_count;
  logic [VB-1:0]               remaining;
  logic                        last;

  int fail_count;
  int pending;
  int beats_checked;
  int quiet = 0;
  int items_sent = 0;
  int changes_sent = 0;
  bit tail = 1'b0;

  always #5 clk = ~clk;

  greedy_coin_change #(.TABLE_DEPTH(DEPTH), .VALUE_BITS(VB)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .denomination(denomination), .amount(amount), .strobe(strobe),
    .coin_value(coin_value), .coin_count(coin_count), .remaining(remaining), .last(last)
  );

  gcc_checker #(.DEPTH(DEPTH), .VB(VB)) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .denomination(denomination), .amount(amount), .strobe(strobe),
    .coin_value(coin_value), .coin_count(coin_count), .remaining(remaining), .last(last),
    .fail_count(fail_count), .pending(pending), .beats_checked(beats_checked)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("[greedy_coin_change] ERROR");
      $finish;
    end
  end

  function automatic logic [VB-1:0] rnd();
    return VB'($urandom);
  endfunction

  function automatic logic [gcc_pkg::OP_BITS-1:0] rnd_op();
    logic [31:0] r;
    r = $urandom;
    return r[gcc_pkg::OP_BITS-1:0];
  endfunction

  task automatic issue(input logic [gcc_pkg::OP_BITS-1:0] o, input logic [VB-1:0] d,
                       input logic [VB-1:0] a);
    @(negedge clk);
    start <= 1'b1;
    op <= o;
    denomination <= d;
    amount <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (o == gcc_pkg::OP_CHANGE) changes_sent++;
  endtask

  task automatic pause(input int n);
    @(negedge clk);
    start <= 1'b0;
    op <= rnd_op();
    denomination <= rnd();
    amount <= rnd();
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic maybe_pause();
    if (!tail && $urandom_range(0, 3) == 0) pause($urandom_range(1, 9));
  endtask

  function automatic logic [VB-1:0] pick_denom();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return rnd();
      2:       return VB'(1);
      3, 4:    return VB'($urandom_range(1, 20));
      5, 6:    return VB'($urandom_range(1, 200));
      7:       return 16'd1 << $urandom_range(0, 15);
      8:       return '1;
      default: return VB'($urandom_range(1, 2000));
    endcase
  endfunction

  function automatic logic [VB-1:0] pick_amount();
    case ($urandom_range(0, 7))
      0, 1:    return rnd();
      2:       return '0;
      3:       return '1;
      4:       return VB'($urandom_range(0, 20000));
      default: return VB'($urandom_range(0, 1000));
    endcase
  endfunction

  initial begin
    int n_adds;
    int n_chg;
    int n_noise;
    logic [VB-1:0] d;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    issue(gcc_pkg::OP_CHANGE, rnd(), 16'hFFFF);
    issue(gcc_pkg::OP_ADD, 16'd0, rnd());
    issue(gcc_pkg::OP_ADD, 16'hFFFF, rnd());
    issue(gcc_pkg::OP_ADD, 16'd1, rnd());
    issue(gcc_pkg::OP_ADD, 16'd7, rnd());
    issue(gcc_pkg::OP_ADD, 16'd7, rnd());
    issue(gcc_pkg::OP_CHANGE, rnd(), 16'hFFFF);
    issue(gcc_pkg::OP_CHANGE, rnd(), 16'd0);
    issue(OP_SPARE, rnd(), rnd());
    repeat (12) issue(gcc_pkg::OP_ADD, VB'($urandom_range(2, 500)), rnd());
    issue(gcc_pkg::OP_ADD, 16'd9, rnd());
    issue(gcc_pkg::OP_CHANGE, rnd(), 16'hFFFF);
    issue(gcc_pkg::OP_CLEAR, rnd(), rnd());
    issue(gcc_pkg::OP_ADD, 16'd4, rnd());
    issue(gcc_pkg::OP_CHANGE, rnd(), 16'hFFFF);
    issue(gcc_pkg::OP_CHANGE, rnd(), 16'd3);

    while (items_sent < ITEMS) begin
      tail = (items_sent > ITEMS * 85 / 100);
      if ($urandom_range(0, 99) < 85) begin
        maybe_pause();
        issue(gcc_pkg::OP_CLEAR, rnd(), rnd());
        n_adds = $urandom_range(1, 20);
        for (int i = 0; i < n_adds; i++) begin
          maybe_pause();
          d = pick_denom();
          issue(gcc_pkg::OP_ADD, d, rnd());
        end
        n_chg = $urandom_range(1, 4);
        for (int i = 0; i < n_chg; i++) begin
          maybe_pause();
          issue(gcc_pkg::OP_CHANGE, rnd(), pick_amount());
        end
      end else begin
        n_noise = $urandom_range(1, 6);
        for (int i = 0; i < n_noise; i++) begin
          maybe_pause();
          issue(rnd_op(), ($urandom_range(0, 1) ? pick_denom() : rnd()), pick_amount());
        end
      end
    end

    @(negedge clk);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Covered %0d commands, %0d change requests, %0d result beats checked",
             items_sent, changes_sent, beats_checked);
    if (fail_count == 0) begin
      $display("[greedy_coin_change] OK");
    end else begin
      $display("[greedy_coin_change] ERROR");
    end
    $finish;
  end
endmodule

[filelist.f]
src/gcc_pkg.sv
src/gcc_divider.sv
src/greedy_coin_change.sv
verif/gcc_checker.sv
verif/tb_greedy_coin_change.sv
